@@ sv/free_extent_allocator_core_defines.svh @@
// assertion macros for the free extent allocator
`ifndef FREE_EXTENT_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_EXTENT_ALLOCATOR_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define FEA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fea_pkg.sv @@
// ----------------------------------------------------------------------------
// fea_pkg
// types and constants of the free extent allocator
// ----------------------------------------------------------------------------
package fea_pkg;
  localparam int MaxGaps     = 256;
  localparam int ClusterBits = 40;
  localparam int IdxBits     = $clog2(MaxGaps);
  localparam int CntBits     = IdxBits + 1;
  localparam int SlackBits   = 16;
  localparam int PaddrBits   = 3;

  typedef logic [ClusterBits-1:0] cluster_t;
  typedef logic [IdxBits-1:0]     idx_t;
  typedef logic [CntBits-1:0]     cnt_t;

  localparam logic [1:0] ReqFind   = 2'd0;
  localparam logic [1:0] ReqAlloc  = 2'd1;
  localparam logic [1:0] ReqFree   = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoGap   = 2'd1;
  localparam logic [1:0] StOverrun = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [PaddrBits-1:0] AddrMinSlack = '0;
  localparam logic [SlackBits-1:0] MinSlackReset = 16'd512;

  typedef struct packed {
    logic [1:0] req_type;
    cluster_t   extent_start;
    cluster_t   extent_length;
    logic       exclude_valid;
    cluster_t   exclude_start;
    logic       behind_only;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    cluster_t   gap_start;
    cluster_t   gap_length;
  } rsp_t;
endpackage

@@ sv/fea_if.sv @@
// ----------------------------------------------------------------------------
// fea_req_if / fea_rsp_if
// valid/ready channels of the allocator
// ----------------------------------------------------------------------------
interface fea_req_if;
  logic             valid;
  logic             ready;
  fea_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fea_rsp_if;
  logic             valid;
  logic             ready;
  fea_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/fea_ram.sv @@
// ----------------------------------------------------------------------------
// fea_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module fea_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/fea_scan.sv @@
// ----------------------------------------------------------------------------
// fea_scan
// sequencer: scans the gap table once per pass and updates it
// ----------------------------------------------------------------------------
module fea_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   min_slack_i,
  fea_req_if.sink       req,
  fea_rsp_if.source     rsp
);
  import fea_pkg::*;
  `include "free_extent_allocator_core_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RD, S_WR, S_OUT
  } state_e;

  state_e   state_q;
  req_t     r_q;
  logic [1:0] pass_q;
  cnt_t     cnt_q;
  logic     rd_vld_q;
  idx_t     rd_idx_q;
  logic [MaxGaps-1:0] valid_q;
  cluster_t thr_q;

  logic     pa_q, pb_q;
  idx_t     ia_q, ib_q;
  cluster_t sa_q, la_q, lb_q;
  logic     fr_q;
  idx_t     ifr_q;

  logic     wr_en_q;
  idx_t     wr_idx_q;
  cluster_t ws_q, wl_q;
  rsp_t     rsp_q;
  logic     rsp_v_q;

  cluster_t s_rd, l_rd;
  idx_t     raddr;

  fea_ram #(.Width(ClusterBits), .Depth(MaxGaps)) u_starts (
    .clk_i, .we_i(wr_en_q), .waddr_i(wr_idx_q), .wdata_i(ws_q),
    .raddr_i(raddr), .rdata_o(s_rd));
  fea_ram #(.Width(ClusterBits), .Depth(MaxGaps)) u_lens (
    .clk_i, .we_i(wr_en_q), .waddr_i(wr_idx_q), .wdata_i(wl_q),
    .raddr_i(raddr), .rdata_o(l_rd));

  assign raddr = (state_q == S_RD) ? ib_q : cnt_q[IdxBits-1:0];

  // threshold max(size+size/2, size+slack) saturating
  logic [ClusterBits:0] t1, t2;
  cluster_t t1s, t2s;
  always_comb begin
    t1 = {1'b0, req.data.extent_length} + {2'b0, req.data.extent_length[ClusterBits-1:1]};
    t2 = {1'b0, req.data.extent_length} + (ClusterBits+1)'(min_slack_i);
    t1s = t1[ClusterBits] ? '1 : t1[ClusterBits-1:0];
    t2s = t2[ClusterBits] ? '1 : t2[ClusterBits-1:0];
  end

  // per-entry evaluation
  logic ok, elig, cand, better_a, better_b;
  cluster_t fend;
  always_comb begin
    ok = rd_vld_q && valid_q[rd_idx_q];
    elig = ok && !(r_q.exclude_valid && s_rd == r_q.exclude_start)
           && !(r_q.exclude_valid && r_q.behind_only && s_rd <= r_q.exclude_start);
    fend = r_q.extent_start + r_q.extent_length;
    cand = 1'b0;
    better_a = 1'b0;
    better_b = 1'b0;
    case (r_q.req_type)
      ReqFind: begin
        case (pass_q)
          2'd0: cand = elig && l_rd == r_q.extent_length;
          2'd1: cand = elig && l_rd > thr_q;
          default: cand = elig && l_rd >= r_q.extent_length;
        endcase
        case (pass_q)
          2'd0: better_a = !pa_q || s_rd < sa_q;
          2'd1: better_a = !pa_q || l_rd < la_q || (l_rd == la_q && s_rd < sa_q);
          default: better_a = !pa_q || l_rd > la_q || (l_rd == la_q && s_rd < sa_q);
        endcase
      end
      ReqAlloc: begin
        cand = ok && s_rd == r_q.extent_start;
        better_a = !pa_q;
      end
      default: begin
        cand = ok && s_rd < r_q.extent_start;
        better_a = !pa_q || s_rd > sa_q;
        better_b = ok && !pb_q && s_rd == fend;
      end
    endcase
  end

  logic last;
  assign last = cnt_q == cnt_t'(MaxGaps);

  // left neighbour gap ends exactly where the extent being freed starts
  logic mp;
  assign mp = pa_q && (sa_q + la_q) == r_q.extent_start;

  assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      rsp_v_q <= 1'b0;
      wr_en_q <= 1'b0;
      rd_vld_q <= 1'b0;
      cnt_q <= '0;
      pass_q <= '0;
      pa_q <= 1'b0; pb_q <= 1'b0; fr_q <= 1'b0;
    end else begin
      if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r_q <= req.data;
            thr_q <= (t1s > t2s) ? t1s : t2s;
            pass_q <= '0;
            cnt_q <= '0;
            rd_vld_q <= 1'b0;
            pa_q <= 1'b0; pb_q <= 1'b0; fr_q <= 1'b0;
            if (req.data.req_type == ReqFree &&
                (req.data.extent_length == '0 ||
                 req.data.extent_start + req.data.extent_length < req.data.extent_start)) begin
              rsp_q <= '{(req.data.extent_length == '0) ? StOk : StOverrun,
                         req.data.extent_start, '0};
              state_q <= S_OUT;
            end else if (req.data.req_type == ReqFind || req.data.req_type == ReqAlloc ||
                         req.data.req_type == ReqFree) begin
              state_q <= S_SCAN;
            end else begin
              rsp_q <= '{StNoGap, '0, '0};
              state_q <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (!last) cnt_q <= cnt_q + 1'b1;
          rd_vld_q <= !last;
          rd_idx_q <= cnt_q[IdxBits-1:0];
          if (!last && !fr_q && !valid_q[cnt_q[IdxBits-1:0]]) begin
            fr_q <= 1'b1;
            ifr_q <= cnt_q[IdxBits-1:0];
          end
          if (cand && better_a) begin
            pa_q <= 1'b1; ia_q <= rd_idx_q; sa_q <= s_rd; la_q <= l_rd;
          end
          if (better_b) begin
            pb_q <= 1'b1; ib_q <= rd_idx_q; lb_q <= l_rd;
          end
          if (last && !rd_vld_q) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          case (r_q.req_type)
            ReqFind: begin
              if (pa_q) begin
                rsp_q <= '{StOk, sa_q, la_q};
                state_q <= S_OUT;
              end else if (pass_q == 2'd2) begin
                rsp_q <= '{StNoGap, '0, '0};
                state_q <= S_OUT;
              end else begin
                pass_q <= pass_q + 1'b1;
                cnt_q <= '0;
                state_q <= S_SCAN;
              end
            end
            ReqAlloc: begin
              state_q <= S_OUT;
              if (!pa_q) begin
                rsp_q <= '{StNoGap, '0, '0};
              end else if (la_q < r_q.extent_length) begin
                rsp_q <= '{StOverrun, sa_q, la_q};
              end else if (la_q > r_q.extent_length) begin
                wr_en_q <= 1'b1; wr_idx_q <= ia_q;
                ws_q <= sa_q + r_q.extent_length;
                wl_q <= la_q - r_q.extent_length;
                rsp_q <= '{StOk, sa_q + r_q.extent_length, la_q - r_q.extent_length};
              end else begin
                valid_q[ia_q] <= 1'b0;
                rsp_q <= '{StOk, r_q.extent_start, '0};
              end
            end
            default: begin
              state_q <= S_OUT;
              if (mp && pb_q) begin
                wr_en_q <= 1'b1; wr_idx_q <= ia_q; ws_q <= sa_q;
                wl_q <= la_q + r_q.extent_length + lb_q;
                valid_q[ib_q] <= 1'b0;
                rsp_q <= '{StOk, sa_q, la_q + r_q.extent_length + lb_q};
              end else if (mp) begin
                wr_en_q <= 1'b1; wr_idx_q <= ia_q; ws_q <= sa_q;
                wl_q <= la_q + r_q.extent_length;
                rsp_q <= '{StOk, sa_q, la_q + r_q.extent_length};
              end else if (pb_q) begin
                wr_en_q <= 1'b1; wr_idx_q <= ib_q; ws_q <= r_q.extent_start;
                wl_q <= lb_q + r_q.extent_length;
                rsp_q <= '{StOk, r_q.extent_start, lb_q + r_q.extent_length};
              end else if (!fr_q) begin
                rsp_q <= '{StFull, r_q.extent_start, '0};
              end else begin
                wr_en_q <= 1'b1; wr_idx_q <= ifr_q; ws_q <= r_q.extent_start;
                wl_q <= r_q.extent_length;
                valid_q[ifr_q] <= 1'b1;
                rsp_q <= '{StOk, r_q.extent_start, r_q.extent_length};
              end
            end
          endcase
        end
        S_OUT: begin
          wr_en_q <= 1'b0;
          rsp_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FEA_ASSERT(a_no_accept_busy, clk_i, rst_ni,
    !(req.valid && req.ready && state_q != S_IDLE), "accept while busy")
  `FEA_ASSERT_NEXT(a_out_to_rsp, clk_i, rst_ni, state_q == S_OUT, rsp.valid,
    "result not shown after decision")
  `FEA_ASSERT(a_pass_range, clk_i, rst_ni, pass_q != 2'd3, "find pass overflow")
endmodule

@@ sv/fea_cfg.sv @@
// ----------------------------------------------------------------------------
// fea_cfg
// apb register for min_slack
// ----------------------------------------------------------------------------
module fea_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fea_pkg::PaddrBits-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [15:0]                    min_slack_o
);
  import fea_pkg::*;
  logic [SlackBits-1:0] slack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q <= MinSlackReset;
    end else if (psel && penable && pwrite && paddr == AddrMinSlack) begin
      slack_q <= pwdata[SlackBits-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrMinSlack) ? {16'b0, slack_q} : '0;
  assign min_slack_o = slack_q;
endmodule

@@ sv/free_extent_allocator_core.sv @@
// ----------------------------------------------------------------------------
// free_extent_allocator_core
// best-fit free extent table with coalescing
// ----------------------------------------------------------------------------
// A request is served by scans of the 256-entry gap table through a memory
// with registered read: allocate and free take one scan, and a find scans
// once per tier tried, in order exact size, larger gap, largest gap, and
// answers with no gap once the largest-gap tier finds none. A free of zero
// length or past the last cluster and the unused request code are answered
// without a scan. One request is worked on at a time; the next is taken once
// the response has been transferred.
module free_extent_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fea_pkg::PaddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  fea_req_if.sink                       req,
  fea_rsp_if.source                     rsp
);
  import fea_pkg::*;
  logic [15:0] min_slack;

  fea_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .min_slack_o(min_slack));

  fea_scan u_scan (
    .clk_i, .rst_ni, .min_slack_i(min_slack), .req(req), .rsp(rsp));
endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the free extent allocator core
// ----------------------------------------------------------------------------
// Drives find, allocate and free requests through the request channel, with
// random gaps on the request side and random stalls on the response side.
// A gap table kept in the bench predicts each response, and every response is
// compared field by field with the oldest prediction. The min_slack register
// is written over the APB port between phases, while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import fea_pkg::*;

  localparam int unsigned CycleLimit = 8000000;
  localparam cluster_t    ClusterMax = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  fea_req_if req ();
  fea_rsp_if rsp ();

  free_extent_allocator_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req.sink),
    .rsp     (rsp.source)
  );

  // bench copy of the gap table
  cluster_t        tbl_start [MaxGaps];
  cluster_t        tbl_len [MaxGaps];
  bit              tbl_used [MaxGaps];
  logic [15:0]     slack;
  rsp_t            expected_rsp [$];
  int unsigned     fail_cnt;
  int unsigned     cycle_cnt;
  int unsigned     req_idle_pct;
  int unsigned     rsp_stall_pct;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("** free_extent_allocator_core: FAILED **");
      $finish;
    end
  end

  function automatic cluster_t sat_sum(cluster_t a, cluster_t b);
    logic [ClusterBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ClusterBits] ? ClusterMax : s[ClusterBits-1:0];
  endfunction

  function automatic bit can_pick(int i, req_t r);
    if (!tbl_used[i]) return 0;
    if (r.exclude_valid && tbl_start[i] == r.exclude_start) return 0;
    if (r.exclude_valid && r.behind_only && tbl_start[i] <= r.exclude_start) return 0;
    return 1;
  endfunction

  function automatic int best_gap(req_t r);
    int       pick;
    cluster_t sz;
    cluster_t thr;
    cluster_t t1;
    cluster_t t2;
    pick = -1;
    sz = r.extent_length;
    for (int i = 0; i < MaxGaps; i++)
      if (can_pick(i, r) && tbl_len[i] == sz)
        if (pick < 0 || tbl_start[i] < tbl_start[pick]) pick = i;
    if (pick >= 0) return pick;
    t1 = sat_sum(sz, sz >> 1);
    t2 = sat_sum(sz, cluster_t'(slack));
    thr = (t1 > t2) ? t1 : t2;
    for (int i = 0; i < MaxGaps; i++)
      if (can_pick(i, r) && tbl_len[i] > thr)
        if (pick < 0 || tbl_len[i] < tbl_len[pick] ||
            (tbl_len[i] == tbl_len[pick] && tbl_start[i] < tbl_start[pick])) pick = i;
    if (pick >= 0) return pick;
    for (int i = 0; i < MaxGaps; i++)
      if (can_pick(i, r) && tbl_len[i] >= sz)
        if (pick < 0 || tbl_len[i] > tbl_len[pick] ||
            (tbl_len[i] == tbl_len[pick] && tbl_start[i] < tbl_start[pick])) pick = i;
    return pick;
  endfunction

  function automatic int gap_at(cluster_t s);
    for (int i = 0; i < MaxGaps; i++)
      if (tbl_used[i] && tbl_start[i] == s) return i;
    return -1;
  endfunction

  function automatic rsp_t mk_rsp(logic [1:0] st, cluster_t gs, cluster_t gl);
    rsp_t o;
    o.status = st;
    o.gap_start = gs;
    o.gap_length = gl;
    return o;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    int       g;
    int       lft;
    int       rgt;
    bit       merge_l;
    cluster_t s;
    cluster_t len;
    cluster_t e;
    s = r.extent_start;
    len = r.extent_length;
    case (r.req_type)
      ReqFind: begin
        g = best_gap(r);
        if (g < 0) return mk_rsp(StNoGap, '0, '0);
        return mk_rsp(StOk, tbl_start[g], tbl_len[g]);
      end
      ReqAlloc: begin
        g = gap_at(s);
        if (g < 0) return mk_rsp(StNoGap, '0, '0);
        if (tbl_len[g] < len) return mk_rsp(StOverrun, tbl_start[g], tbl_len[g]);
        if (tbl_len[g] > len) begin
          tbl_start[g] = tbl_start[g] + len;
          tbl_len[g] = tbl_len[g] - len;
          return mk_rsp(StOk, tbl_start[g], tbl_len[g]);
        end
        tbl_used[g] = 0;
        return mk_rsp(StOk, s, '0);
      end
      ReqFree: begin
        e = s + len;
        if (len == '0) return mk_rsp(StOk, s, '0);
        if (e < s) return mk_rsp(StOverrun, s, '0);
        lft = -1;
        for (int i = 0; i < MaxGaps; i++)
          if (tbl_used[i] && tbl_start[i] < s)
            if (lft < 0 || tbl_start[i] > tbl_start[lft]) lft = i;
        merge_l = (lft >= 0) && (cluster_t'(tbl_start[lft] + tbl_len[lft]) == s);
        rgt = gap_at(e);
        if (merge_l && rgt >= 0) begin
          tbl_len[lft] = tbl_len[lft] + len + tbl_len[rgt];
          tbl_used[rgt] = 0;
          return mk_rsp(StOk, tbl_start[lft], tbl_len[lft]);
        end
        if (merge_l) begin
          tbl_len[lft] = tbl_len[lft] + len;
          return mk_rsp(StOk, tbl_start[lft], tbl_len[lft]);
        end
        if (rgt >= 0) begin
          tbl_start[rgt] = s;
          tbl_len[rgt] = tbl_len[rgt] + len;
          return mk_rsp(StOk, s, tbl_len[rgt]);
        end
        for (int i = 0; i < MaxGaps; i++)
          if (!tbl_used[i]) begin
            tbl_used[i] = 1;
            tbl_start[i] = s;
            tbl_len[i] = len;
            return mk_rsp(StOk, s, len);
          end
        return mk_rsp(StFull, s, '0);
      end
      default: return mk_rsp(StNoGap, '0, '0);
    endcase
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < MaxGaps; i++) n += tbl_used[i];
    return n;
  endfunction

  function automatic int any_used();
    int q [$];
    for (int i = 0; i < MaxGaps; i++) if (tbl_used[i]) q.insert(q.size(), i);
    if (q.size() == 0) return -1;
    return q[$urandom_range(q.size() - 1)];
  endfunction

  function automatic req_t mk_req(logic [1:0] t, cluster_t s, cluster_t l,
                                  logic xv = 0, cluster_t xs = '0, logic bo = 0);
    req_t r;
    r.req_type = t;
    r.extent_start = s;
    r.extent_length = l;
    r.exclude_valid = xv;
    r.exclude_start = xs;
    r.behind_only = bo;
    return r;
  endfunction

  task automatic send(req_t r);
    if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < req_idle_pct) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk_i); while (!req.ready);
    expected_rsp.insert(expected_rsp.size(), apply_request(r));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_slack(logic [15:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrMinSlack;
    pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    slack = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== v) begin
      $error("min_slack readback: expected %0h actual %0h", v, prdata[15:0]);
      fail_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected response transfer");
          fail_cnt++;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.data.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp.data.status);
            fail_cnt++;
          end
          if (rsp.data.gap_start !== e.gap_start) begin
            $error("gap_start: expected %0h actual %0h", e.gap_start, rsp.data.gap_start);
            fail_cnt++;
          end
          if (rsp.data.gap_length !== e.gap_length) begin
            $error("gap_length: expected %0h actual %0h", e.gap_length,
                   rsp.data.gap_length);
            fail_cnt++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    send(mk_req(ReqFind, '0, 40'd10));
    send(mk_req(ReqAlloc, 40'd100, 40'd1));
    send(mk_req(ReqFree, 40'd100, '0));
    send(mk_req(ReqFree, ClusterMax, 40'd2));
    send(mk_req(ReqFree, 40'd1000, 40'd100));
    send(mk_req(ReqFree, 40'd900, 40'd100));
    send(mk_req(ReqFree, 40'd1100, 40'd50));
    send(mk_req(ReqFree, 40'd1300, 40'd50));
    send(mk_req(ReqFree, 40'd1150, 40'd150));
    send(mk_req(ReqFree, 40'd5000, 40'd20));
    send(mk_req(ReqFree, 40'd6000, 40'd2000));
    send(mk_req(ReqFind, '0, 40'd20));
    send(mk_req(ReqFind, '0, 40'd20, 1'b1, 40'd5000));
    send(mk_req(ReqFind, '0, 40'd30, 1'b0, 40'd7000, 1'b1));
    send(mk_req(ReqFind, '0, 40'd1500, 1'b1, 40'd900, 1'b1));
    send(mk_req(ReqFind, '0, 40'd3000));
    send(mk_req(ReqFree, 40'd5000, 40'd5));
    send(mk_req(ReqAlloc, 40'd5000, 40'd4));
    send(mk_req(ReqAlloc, 40'd6000, 40'd2001));
    send(mk_req(ReqAlloc, 40'd6000, 40'd2000));
    send(mk_req(ReqFree, 40'h80_0000_0000, ClusterMax - 40'h80_0000_0000));
    send(mk_req(ReqFind, '0, ClusterMax));
    send(mk_req(ReqFind, '0, ClusterMax - 40'd10));
    send(mk_req(ReqUnused, ClusterMax, ClusterMax, 1'b1, ClusterMax, 1'b1));
    send(mk_req(ReqAlloc, 40'h80_0000_0000, ClusterMax - 40'h80_0000_0000));
  endtask

  task automatic test_table_full();
    cluster_t base;
    int       k;
    int       g;
    base = 40'h10_0000;
    k = 0;
    while (used_count() < MaxGaps) begin
      send(mk_req(ReqFree, base + cluster_t'(4 * k), cluster_t'(1 + (k % 2))));
      k++;
    end
    send(mk_req(ReqFree, base + cluster_t'(4 * k + 100), 40'd1));
    send(mk_req(ReqFree, base + cluster_t'(4 * k + 1), 40'd1));
    while (used_count() > MaxGaps / 2) begin
      g = any_used();
      send(mk_req(ReqAlloc, tbl_start[g], tbl_len[g]));
    end
  endtask

  function automatic req_t rand_req();
    req_t         r;
    int           g;
    int           w;
    logic [127:0] raw;
    r = mk_req(ReqFind, '0, '0);
    w = $urandom_range(99);
    g = any_used();
    if (w < 6) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      r = raw[$bits(req_t)-1:0];
      if ($urandom_range(1)) r.req_type = ReqUnused;
      return r;
    end
    if (w < 45 || g < 0) begin
      r.req_type = ReqFree;
      r.extent_start = cluster_t'($urandom_range(16383));
      r.extent_length = cluster_t'($urandom_range(1, 200));
      if (g >= 0 && $urandom_range(2) == 0)
        r.extent_start = tbl_start[g] + tbl_len[g];
      else if (g >= 0 && $urandom_range(3) == 0)
        r.extent_start = tbl_start[g] - r.extent_length;
      return r;
    end
    if (w < 72) begin
      r.req_type = ReqAlloc;
      r.extent_start = ($urandom_range(9) == 0) ? cluster_t'($urandom_range(16383)) :
                       tbl_start[g];
      r.extent_length = $urandom_range(0, 4) == 0 ? tbl_len[g] :
                        cluster_t'($urandom_range(0, 210));
      return r;
    end
    r.req_type = ReqFind;
    r.extent_length = $urandom_range(1) ? tbl_len[g] : cluster_t'($urandom_range(0, 600));
    r.exclude_valid = 1'($urandom_range(1));
    r.behind_only = 1'($urandom_range(1));
    g = any_used();
    r.exclude_start = $urandom_range(3) == 0 ? cluster_t'($urandom_range(16383)) :
                      tbl_start[g];
    return r;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) req_idle_pct = 0;
      if (i == n / 3) rsp_stall_pct = 0;
      if (i == n / 2) req_idle_pct = 34;
      if (i == n / 2) rsp_stall_pct = 34;
      send(rand_req());
    end
  endtask

  task automatic test_slack_settings();
    write_slack(16'd0);
    test_random(120);
    write_slack(16'hffff);
    test_random(120);
    write_slack(16'd40);
    test_random(120);
    write_slack(16'($urandom_range(1, 300)));
    test_random(140);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    cycle_cnt = 0;
    fail_cnt = 0;
    req_idle_pct = 34;
    rsp_stall_pct = 34;
    slack = MinSlackReset;
    for (int i = 0; i < MaxGaps; i++) tbl_used[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_slack_settings();
    drain();
    if (fail_cnt == 0) begin
      $display("** free_extent_allocator_core: PASSED **");
    end else begin
      $display("** free_extent_allocator_core: FAILED **");
    end
    $finish;
  end
endmodule
